@@ src/vtcb_pkg.sv @@
// Package for the value-to-column bitset indexer.
// Holds the request and result payload types, request codes and the sequencer state type.
// No dependencies.
`default_nettype none

package vtcb_pkg;

  localparam logic [1:0] REQ_FIRST  = 2'd0;
  localparam logic [1:0] REQ_SECOND = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] cell_value;
    logic [5:0]         column;
  } req_t;

  typedef struct packed {
    logic [63:0] attribute_bits;
    logic        last_entry;
    logic        error_seen;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_BIT_RD,
    S_BIT_WR,
    S_INSERT,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

endpackage

`default_nettype wire

@@ src/vtcb_value_store.sv @@
// Stored distinct values of the indexer, with the shared equality comparator.
// One write port, one registered read port; the comparator checks the read word against the key.
// Uses no package items.
`default_nettype none

module vtcb_value_store #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [31:0]       wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic [31:0]       key,
  output logic                   match
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign match = (rd_data == key);

endmodule

`default_nettype wire

@@ src/vtcb_bitset_store.sv @@
// Per-entry attribute bitsets of the indexer.
// A write either stores the given bits or merges them into the word last read.
// Uses no package items.
`default_nettype none

module vtcb_bitset_store #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int WIDTH  = 64
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic              wr_merge,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_bits,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] wr_word;

  assign wr_word = wr_merge ? (rd_data | wr_bits) : wr_bits;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/value_to_column_bitset_indexer.sv @@
// Value-to-column bitset indexer: top level with the request sequencer and result register.
// Depends on vtcb_pkg, vtcb_value_store and vtcb_bitset_store.
//
// A cell request compares its value against one stored value per cycle through the single
// read port of the value memory and its one comparator. On an empty table a second-table cell
// goes straight back to idle and a first-table cell is inserted at once; otherwise the scan runs
// over the stored entries, with the read-modify-write of the bitset last on a hit.
// A finish request reads the bitsets one at a time, each read followed by a load into the
// result register that waits out any stall on the result side. The block accepts no request
// while one is in progress; a waiting result does not hold off the next request.
`default_nettype none

module value_to_column_bitset_indexer #(
  parameter int MAX_ENTRIES = 64,
  parameter int ATTR_BITS   = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire vtcb_pkg::req_t req_data,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output vtcb_pkg::rsp_t     rsp_data,
  input  wire logic          cfg_wr_en,
  input  wire logic [5:0]    cfg_wr_data
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);
  localparam logic [6:0]       ATTR_LIMIT = 7'(ATTR_BITS);

  vtcb_pkg::state_t state, state_next;

  logic [5:0]       r_columns;
  logic [CNT_W-1:0] entry_count;
  logic             sticky_error;
  logic [1:0]       req_type;
  logic [31:0]      key;
  logic [6:0]       pos;
  logic [CNT_W-1:0] issue_idx;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_idx;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] emit_idx;

  logic             accept;
  logic             match;
  logic             hit;
  logic             scan_end;
  logic             pos_ok;
  logic             slot_free;
  logic             emit_last;
  logic [6:0]       pos_next;
  logic [ATTR_BITS-1:0] bit_mask;
  logic [ATTR_BITS-1:0] bits_rd;

  logic             val_wr_en;
  logic             val_rd_en;
  logic [IDX_W-1:0] val_rd_addr;
  logic             bit_wr_en;
  logic             bit_wr_merge;
  logic [IDX_W-1:0] bit_wr_addr;
  logic [ATTR_BITS-1:0] bit_wr_bits;
  logic             bit_rd_en;
  logic [IDX_W-1:0] bit_rd_addr;

  assign accept    = req_valid && !req_stall;
  assign hit       = pend_valid && match;
  assign scan_end  = pend_valid && ((CNT_W'(pend_idx) + 1'b1) == entry_count);
  assign pos_ok    = pos < ATTR_LIMIT;
  assign bit_mask  = {{(ATTR_BITS-1){1'b0}}, 1'b1} << pos;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign emit_last = (CNT_W'(emit_idx) + 1'b1) == entry_count;
  assign pos_next  = (req_data.req_type == vtcb_pkg::REQ_SECOND)
                   ? ({1'b0, req_data.column} + {1'b0, r_columns})
                   : {1'b0, req_data.column};

  vtcb_value_store #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_values (
    .clk     (clk),
    .wr_en   (val_wr_en),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data (key),
    .rd_en   (val_rd_en),
    .rd_addr (val_rd_addr),
    .key     (key),
    .match   (match)
  );

  vtcb_bitset_store #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (IDX_W),
    .WIDTH  (ATTR_BITS)
  ) u_bitsets (
    .clk      (clk),
    .wr_en    (bit_wr_en),
    .wr_merge (bit_wr_merge),
    .wr_addr  (bit_wr_addr),
    .wr_bits  (bit_wr_bits),
    .rd_en    (bit_rd_en),
    .rd_addr  (bit_rd_addr),
    .rd_data  (bits_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      vtcb_pkg::S_IDLE: begin
        if (accept) begin
          case (req_data.req_type)
            vtcb_pkg::REQ_FIRST: begin
              state_next = (entry_count == '0) ? vtcb_pkg::S_INSERT : vtcb_pkg::S_SCAN;
            end
            vtcb_pkg::REQ_SECOND: begin
              state_next = (entry_count == '0) ? vtcb_pkg::S_IDLE : vtcb_pkg::S_SCAN;
            end
            vtcb_pkg::REQ_FINISH: begin
              state_next = (entry_count == '0) ? vtcb_pkg::S_IDLE : vtcb_pkg::S_EMIT_RD;
            end
            default: begin
              state_next = vtcb_pkg::S_IDLE;
            end
          endcase
        end
      end
      vtcb_pkg::S_SCAN: begin
        if (hit) begin
          state_next = pos_ok ? vtcb_pkg::S_BIT_RD : vtcb_pkg::S_IDLE;
        end else if (scan_end) begin
          if (req_type == vtcb_pkg::REQ_FIRST && entry_count != FULL_COUNT) begin
            state_next = vtcb_pkg::S_INSERT;
          end else begin
            state_next = vtcb_pkg::S_IDLE;
          end
        end
      end
      vtcb_pkg::S_BIT_RD:  state_next = vtcb_pkg::S_BIT_WR;
      vtcb_pkg::S_BIT_WR:  state_next = vtcb_pkg::S_IDLE;
      vtcb_pkg::S_INSERT:  state_next = vtcb_pkg::S_IDLE;
      vtcb_pkg::S_EMIT_RD: state_next = vtcb_pkg::S_EMIT_LD;
      vtcb_pkg::S_EMIT_LD: begin
        if (slot_free) begin
          state_next = emit_last ? vtcb_pkg::S_IDLE : vtcb_pkg::S_EMIT_RD;
        end
      end
      default: state_next = vtcb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_stall    = 1'b1;
    val_wr_en    = 1'b0;
    val_rd_en    = 1'b0;
    val_rd_addr  = issue_idx[IDX_W-1:0];
    bit_wr_en    = 1'b0;
    bit_wr_merge = 1'b0;
    bit_wr_addr  = hit_idx;
    bit_wr_bits  = bit_mask;
    bit_rd_en    = 1'b0;
    bit_rd_addr  = hit_idx;
    case (state)
      vtcb_pkg::S_IDLE: begin
        req_stall = 1'b0;
      end
      vtcb_pkg::S_SCAN: begin
        val_rd_en = (issue_idx < entry_count);
      end
      vtcb_pkg::S_BIT_RD: begin
        bit_rd_en = 1'b1;
      end
      vtcb_pkg::S_BIT_WR: begin
        bit_wr_en    = 1'b1;
        bit_wr_merge = 1'b1;
      end
      vtcb_pkg::S_INSERT: begin
        val_wr_en   = 1'b1;
        bit_wr_en   = 1'b1;
        bit_wr_addr = entry_count[IDX_W-1:0];
        bit_wr_bits = pos_ok ? bit_mask : '0;
      end
      vtcb_pkg::S_EMIT_RD: begin
        bit_rd_en   = 1'b1;
        bit_rd_addr = emit_idx;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= vtcb_pkg::S_IDLE;
      r_columns    <= 6'd1;
      entry_count  <= '0;
      sticky_error <= 1'b0;
      rsp_valid    <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        r_columns <= cfg_wr_data;
      end
      if (state == vtcb_pkg::S_EMIT_LD && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        vtcb_pkg::S_IDLE: begin
          pend_valid <= 1'b0;
          if (accept && req_data.req_type == vtcb_pkg::REQ_FINISH && entry_count == '0) begin
            sticky_error <= 1'b0;
          end
        end
        vtcb_pkg::S_SCAN: begin
          pend_valid <= val_rd_en;
          if (hit) begin
            if (!pos_ok) begin
              sticky_error <= 1'b1;
            end
          end else if (scan_end && req_type == vtcb_pkg::REQ_FIRST &&
                       entry_count == FULL_COUNT) begin
            sticky_error <= 1'b1;
          end
        end
        vtcb_pkg::S_INSERT: begin
          entry_count <= entry_count + 1'b1;
          if (!pos_ok) begin
            sticky_error <= 1'b1;
          end
        end
        vtcb_pkg::S_EMIT_LD: begin
          if (slot_free && emit_last) begin
            entry_count  <= '0;
            sticky_error <= 1'b0;
          end
        end
        default: begin
          pend_valid <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type  <= req_data.req_type;
      key       <= req_data.cell_value;
      pos       <= pos_next;
      issue_idx <= '0;
      emit_idx  <= '0;
    end
    if (val_rd_en) begin
      issue_idx <= issue_idx + 1'b1;
    end
    pend_idx <= issue_idx[IDX_W-1:0];
    if (hit) begin
      hit_idx <= pend_idx;
    end
    if (state == vtcb_pkg::S_EMIT_LD && slot_free) begin
      rsp_data.attribute_bits <= 64'(bits_rd);
      rsp_data.last_entry     <= emit_last;
      rsp_data.error_seen     <= sticky_error;
      emit_idx                <= emit_idx + 1'b1;
    end
  end

endmodule

`default_nettype wire
